@@ hdl/sha256_pkg.sv @@
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions for the SHA-256 hash core.
// ----------------------------------------------------------------------------
package sha256_pkg;

	localparam int unsigned CountWidth = 61;

	typedef logic [31:0] word_t;

	typedef enum logic [2:0] {
		ST_FILL,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	localparam word_t InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [5:0] LenPos  = 6'd56;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t sig0(input word_t x);
		sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sig1(input word_t x);
		sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t bsig0(input word_t x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage

@@ hdl/sha256_if.sv @@
// ----------------------------------------------------------------------------
// sha256_in_if / sha256_out_if
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface sha256_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       is_last;
	modport source (output valid, data_byte, has_byte, is_last, input ready);
	modport sink (input valid, data_byte, has_byte, is_last, output ready);
endinterface

interface sha256_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ hdl/sha256_hash_core.sv @@
// A request that completes a block holds off input while the block is loaded byte
// by byte, the 64 rounds run and the fold adds in; other byte requests do not stall.
// A last request pads to the block end and compresses, maybe again after a second
// pad pass, then emits eight digest words, one per cycle as taken.
// Throughput is set by the byte-serial block load and the single round unit.
// Reset loads the initial hash values and clears the byte count; no memory sweep.
// ----------------------------------------------------------------------------
// sha256_hash_core
// Streaming SHA-256: bytes packed into a block memory, 64-round compression.
// ----------------------------------------------------------------------------
module sha256_hash_core (
	input  logic                 clk,
	input  logic                 arst_n,
	sha256_in_if.sink            in_ch,
	sha256_out_if.source         out_ch
);

	sha256_pkg::state_t state_q, state_d;

	// block memory: byte-wide, one write and one registered read per cycle
	logic [7:0] blk_mem [64];
	logic [7:0] rd_byte_q;
	logic       mem_we;
	logic [5:0] mem_waddr;
	logic [7:0] mem_wdata;
	logic [5:0] mem_raddr;

	logic [sha256_pkg::CountWidth-1:0] count_q;
	logic [5:0]  pos_q;
	logic        final_q;
	logic        second_q;
	logic        spill_q;
	logic        len_done_q;
	logic [6:0]  ctr_q;
	logic [31:0] wacc_q;
	sha256_pkg::word_t wq_q [16];
	sha256_pkg::word_t h_q [8];
	sha256_pkg::word_t v_q [8];
	logic [2:0]  emit_q;

	logic [63:0] bits;
	logic        accept;
	logic        pad_spill;
	sha256_pkg::word_t w_new, w_cur, t1, t2;

	assign accept = in_ch.valid && in_ch.ready;
	assign bits   = {count_q, 3'b000};

	// length goes into a further block when the pad byte lands in the length field
	assign pad_spill = second_q ? spill_q : (pos_q > 6'd55);

	// message schedule word of this round
	assign w_new = sha256_pkg::sig1(wq_q[14]) + wq_q[9] + sha256_pkg::sig0(wq_q[1]) + wq_q[0];
	assign w_cur = (ctr_q < 7'd16) ? wq_q[ctr_q[3:0]] : w_new;

	// round function
	assign t1 = v_q[7] + sha256_pkg::bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ sha256_pkg::RoundK[ctr_q[5:0]] + w_cur;
	assign t2 = sha256_pkg::bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2])
		^ (v_q[1] & v_q[2]));

	// next state and memory port control
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = in_ch.data_byte;
		mem_raddr = ctr_q[5:0];
		in_ch.ready = 1'b0;
		case (state_q)
			sha256_pkg::ST_FILL: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid && in_ch.has_byte) begin
					mem_we = 1'b1;
					if (pos_q == 6'd63) begin
						state_d = sha256_pkg::ST_LOAD;
					end else if (in_ch.is_last) begin
						state_d = sha256_pkg::ST_PAD;
					end
				end else if (in_ch.valid && in_ch.is_last) begin
					state_d = sha256_pkg::ST_PAD;
				end
			end
			sha256_pkg::ST_PAD: begin
				mem_we = 1'b1;
				if (!second_q) begin
					mem_wdata = sha256_pkg::PadByte;
				end else if (!pad_spill && pos_q >= sha256_pkg::LenPos) begin
					mem_wdata = bits[8*(7-pos_q[2:0]) +: 8];
				end else begin
					mem_wdata = 8'h00;
				end
				if (pos_q == 6'd63) begin
					state_d = sha256_pkg::ST_LOAD;
				end
			end
			sha256_pkg::ST_LOAD: begin
				if (ctr_q == 7'd64) begin
					state_d = sha256_pkg::ST_ROUND;
				end
			end
			sha256_pkg::ST_ROUND: begin
				if (ctr_q == 7'd63) begin
					state_d = sha256_pkg::ST_FOLD;
				end
			end
			sha256_pkg::ST_FOLD: begin
				if (final_q && len_done_q) begin
					state_d = sha256_pkg::ST_EMIT;
				end else if (final_q) begin
					state_d = sha256_pkg::ST_PAD;
				end else begin
					state_d = sha256_pkg::ST_FILL;
				end
			end
			sha256_pkg::ST_EMIT: begin
				if (out_ch.ready && emit_q == 3'd7) begin
					state_d = sha256_pkg::ST_FILL;
				end
			end
			default: state_d = sha256_pkg::ST_FILL;
		endcase
	end

	// block memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			blk_mem[mem_waddr] <= mem_wdata;
		end
		rd_byte_q <= blk_mem[mem_raddr];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256_pkg::ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	// control counters and hash state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			pos_q      <= '0;
			final_q    <= 1'b0;
			second_q   <= 1'b0;
			spill_q    <= 1'b0;
			len_done_q <= 1'b0;
			ctr_q      <= '0;
			emit_q     <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::InitHash[i];
		end else begin
			case (state_q)
				sha256_pkg::ST_FILL: begin
					ctr_q <= '0;
					if (accept) begin
						final_q    <= in_ch.is_last;
						second_q   <= 1'b0;
						spill_q    <= 1'b0;
						len_done_q <= 1'b0;
						if (in_ch.has_byte) begin
							count_q <= count_q + 1'b1;
							pos_q   <= pos_q + 6'd1;
						end
					end
				end
				sha256_pkg::ST_PAD: begin
					// first pad cycle decides whether the length needs a further block
					if (!second_q) begin
						second_q <= 1'b1;
						spill_q  <= (pos_q > 6'd55);
					end
					pos_q <= pos_q + 6'd1;
					if (pos_q == 6'd63) begin
						len_done_q <= !pad_spill;
					end
				end
				sha256_pkg::ST_LOAD: begin
					if (ctr_q == 7'd64) begin
						ctr_q <= '0;
					end else begin
						ctr_q <= ctr_q + 7'd1;
					end
				end
				sha256_pkg::ST_ROUND: begin
					ctr_q <= ctr_q + 7'd1;
				end
				sha256_pkg::ST_FOLD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					ctr_q   <= '0;
					spill_q <= 1'b0;
					emit_q  <= '0;
				end
				sha256_pkg::ST_EMIT: begin
					if (out_ch.ready) begin
						emit_q <= emit_q + 3'd1;
						if (emit_q == 3'd7) begin
							for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::InitHash[i];
							count_q <= '0;
							pos_q   <= '0;
							final_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath: byte packing, schedule window, working variables
	always_ff @(posedge clk) begin
		case (state_q)
			sha256_pkg::ST_LOAD: begin
				if (ctr_q != 7'd0) begin
					wacc_q <= {wacc_q[23:0], rd_byte_q};
					if (ctr_q[1:0] == 2'd0) begin
						wq_q[ctr_q[5:2] - 4'd1] <= {wacc_q[23:0], rd_byte_q};
					end
				end
				for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			end
			sha256_pkg::ST_ROUND: begin
				if (ctr_q >= 7'd16) begin
					for (int i = 0; i < 15; i++) wq_q[i] <= wq_q[i+1];
					wq_q[15] <= w_cur;
				end
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
			default: ;
		endcase
	end

	// digest output
	assign out_ch.valid       = (state_q == sha256_pkg::ST_EMIT);
	assign out_ch.digest_word = h_q[emit_q];
	assign out_ch.word_index  = emit_q;
	assign out_ch.last_word   = (emit_q == 3'd7);

	a_emit_no_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("input taken while emitting");
	a_emit_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && emit_q != 3'd7) |=> out_ch.valid)
		else $error("digest burst cut short");
	a_round_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha256_pkg::ST_ROUND && ctr_q == 7'd63) |=>
		state_q == sha256_pkg::ST_FOLD) else $error("round count wrong");

endmodule
